// ===== rtl/core/wrm_pkg.sv =====
package wrm_pkg;

	localparam int SAMPLE_W       = 16;
	localparam int DEF_MAX_WINDOW = 32;
	localparam int LEN_W          = 6;
	localparam int LIM_W          = 16;
	localparam int TOL_W          = 24;
	localparam int MEAN_W         = 24;
	localparam int COUNT_W        = 6;
	localparam int FRAC_W         = 8;
	localparam int VAR_SHIFT      = 16;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_LENGTH     = 3'd0,
		REG_HOT_POLARITY_SWAP = 3'd1,
		REG_TARGET_MAGNITUDE  = 3'd2,
		REG_TARGET_SIGN       = 3'd3,
		REG_NEAR_TARGET_LIMIT = 3'd4,
		REG_NEAR_ZERO_LIMIT   = 3'd5,
		REG_MEAN_TOLERANCE    = 3'd6,
		REG_SPREAD_TOLERANCE  = 3'd7
	} cfg_reg_t;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_OLD  = 9'b000000010,
		ST_SQ   = 9'b000000100,
		ST_MUL  = 9'b000001000,
		ST_VAR  = 9'b000010000,
		ST_CMP  = 9'b000100000,
		ST_DIV  = 9'b001000000,
		ST_OUT  = 9'b010000000,
		ST_SPARE = 9'b100000000
	} state_t;

endpackage

// ===== rtl/core/wrm_if.sv =====
interface wrm_in_if;
	import wrm_pkg::*;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample_magnitude;
	logic                sample_sign;
	modport source (output valid, sample_magnitude, sample_sign, input ready);
	modport sink (input valid, sample_magnitude, sample_sign, output ready);
endinterface

interface wrm_out_if;
	import wrm_pkg::*;
	logic               valid;
	logic               ready;
	logic               steady;
	logic               near_target;
	logic               near_zero;
	logic               on_target;
	logic               polarity_correct;
	logic               window_cleared;
	logic [COUNT_W-1:0] sample_count;
	logic [MEAN_W-1:0]  mean_q8;
	modport source (output valid, steady, near_target, near_zero, on_target,
		polarity_correct, window_cleared, sample_count, mean_q8, input ready);
	modport sink (input valid, steady, near_target, near_zero, on_target,
		polarity_correct, window_cleared, sample_count, mean_q8, output ready);
endinterface

interface wrm_cfg_if;
	import wrm_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/wrm_ring.sv =====
module wrm_ring #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns the old contents when both ports hit the same entry.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
		if (we) begin
			mem[waddr] <= wdata;
		end
	end
endmodule

// ===== rtl/core/wrm_div.sv =====
module wrm_div #(
	parameter int N_W = 29,
	parameter int D_W = 6
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] dividend,
	input  logic [D_W-1:0] divisor,
	output logic           busy,
	output logic [N_W-1:0] quotient
);
	localparam int CNT_W = $clog2(N_W + 1);

	logic [N_W-1:0]   quo_q;
	logic [D_W:0]     rem_q;
	logic [D_W-1:0]   dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [D_W:0]     rem_sh;
	logic             take;

	assign rem_sh = {rem_q[D_W-1:0], quo_q[N_W-1]};
	assign take   = rem_sh >= {1'b0, dvs_q};

	// One quotient bit per cycle, restoring.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(N_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? rem_sh - {1'b0, dvs_q} : rem_sh;
			quo_q <= {quo_q[N_W-2:0], take};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;
endmodule

// ===== rtl/core/windowed_regulation_monitor_top.sv =====
// Windowed regulation monitor.
// Samples arrive on the samples channel (magnitude and polarity), one beat per
// sample. Each accepted sample yields exactly one beat on the results channel:
// five status flags, the window cleared flag, the sample count and the Q8 mean.
// Registers are written on the cfg channel (index, data), which is always ready;
// write them only while no sample is in flight.
// A sample passes through the states OLD, SQ, MUL, VAR, CMP, DIV and OUT between
// acceptance and the result beat, and a new sample is taken only after the
// previous one has left the datapath. The serial mean divider, one quotient
// bit per cycle over the Q8 sum, is started in the VAR state; DIV waits for it.
// The window samples live in a small synchronous RAM; the oldest entry is read
// and the new one written in the acceptance cycle.
// Reset clears the window, the sums and the registers to their defaults; the
// RAM itself is not cleared, since only written entries are ever read.
// A stalled receiver holds the result register; the block finishes the next
// sample and then waits until the pending beat has been taken.
module windowed_regulation_monitor_top #(
	parameter int MAX_WINDOW = wrm_pkg::DEF_MAX_WINDOW
) (
	input logic clk,
	input logic arst_n,
	wrm_in_if.sink    samples,
	wrm_out_if.source results,
	wrm_cfg_if.sink   cfg
);
	import wrm_pkg::*;

	localparam int CW     = $clog2(MAX_WINDOW + 1);
	localparam int AW     = $clog2(MAX_WINDOW);
	localparam int EW     = (CW > LEN_W) ? CW : LEN_W;
	localparam int SUM_W  = SAMPLE_W + CW;
	localparam int SQ_W   = 2 * SAMPLE_W + CW;
	localparam int PROD_W = 2 * SUM_W;
	localparam int T_W    = TOL_W + CW;
	localparam int RHS_W  = 2 * T_W;
	localparam int MW     = SUM_W + FRAC_W;

	// Configuration registers.
	logic [LEN_W-1:0] win_len_q;
	logic             hot_swap_q;
	logic [SAMPLE_W-1:0] tgt_mag_q;
	logic             tgt_sign_q;
	logic [LIM_W-1:0] near_tgt_lim_q;
	logic [LIM_W-1:0] near_zero_lim_q;
	logic [TOL_W-1:0] mean_tol_q;
	logic [TOL_W-1:0] spread_tol_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q       <= LEN_W'(10);
			hot_swap_q      <= 1'b0;
			tgt_mag_q       <= '0;
			tgt_sign_q      <= 1'b1;
			near_tgt_lim_q  <= LIM_W'(16);
			near_zero_lim_q <= LIM_W'(16);
			mean_tol_q      <= TOL_W'(256);
			spread_tol_q    <= TOL_W'(256);
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_WINDOW_LENGTH:     win_len_q       <= cfg.data[LEN_W-1:0];
				REG_HOT_POLARITY_SWAP: hot_swap_q      <= cfg.data[0];
				REG_TARGET_MAGNITUDE:  tgt_mag_q       <= cfg.data[SAMPLE_W-1:0];
				REG_TARGET_SIGN:       tgt_sign_q      <= cfg.data[0];
				REG_NEAR_TARGET_LIMIT: near_tgt_lim_q  <= cfg.data[LIM_W-1:0];
				REG_NEAR_ZERO_LIMIT:   near_zero_lim_q <= cfg.data[LIM_W-1:0];
				REG_MEAN_TOLERANCE:    mean_tol_q      <= cfg.data[TOL_W-1:0];
				REG_SPREAD_TOLERANCE:  spread_tol_q    <= cfg.data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// Window state.
	state_t            state_q;
	logic [AW-1:0]     head_q;
	logic [CW-1:0]     held_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SQ_W-1:0]   sq_q;
	logic              last_sign_q;
	logic [SAMPLE_W-1:0] mag_q;
	logic              sgn_q;
	logic              cleared_q;
	logic              drop_q;
	logic [2*SAMPLE_W-1:0] mag_sq_q;
	logic [2*SAMPLE_W-1:0] old_sq_q;
	logic [PROD_W-1:0] p_nsq_q;
	logic [PROD_W-1:0] p_sum2_q;
	logic [T_W-1:0]    tol_n_q;
	logic [MW-1:0]     tn_q;
	logic [MW-1:0]     mt_q;
	logic [PROD_W-1:0] var_q;
	logic [RHS_W-1:0]  rhs_q;
	logic              steady_q;
	logic              on_tgt_q;
	logic              out_valid_q;

	logic              accept;
	logic              clear_c;
	logic [CW-1:0]     h0;
	logic [EW-1:0]     eff_len;
	logic              drop_c;
	logic [CW:0]       old_idx;
	logic [AW-1:0]     raddr;
	logic [SAMPLE_W-1:0] old_mag;
	logic              div_busy;
	logic [MW-1:0]     quotient;
	logic [RHS_W-1:0]  lhs;
	logic [MW-1:0]     s256;
	logic [MW-1:0]     mean_diff;
	logic [SAMPLE_W-1:0] tgt_diff;
	logic              pol_ok;

	assign samples.ready = (state_q == ST_IDLE);
	assign accept        = samples.valid && samples.ready;

	always_comb begin
		if (win_len_q == '0) begin
			eff_len = EW'(1);
		end else if (EW'(win_len_q) > EW'(MAX_WINDOW)) begin
			eff_len = EW'(MAX_WINDOW);
		end else begin
			eff_len = EW'(win_len_q);
		end
	end

	assign clear_c = (held_q != '0) && (samples.sample_sign != last_sign_q) && !hot_swap_q;
	assign h0      = clear_c ? '0 : held_q;
	assign drop_c  = (h0 != '0) && (EW'(h0) >= eff_len);

	always_comb begin
		old_idx = (CW+1)'(head_q) + (CW+1)'(MAX_WINDOW) - (CW+1)'(h0);
		if (old_idx >= (CW+1)'(MAX_WINDOW)) begin
			old_idx = old_idx - (CW+1)'(MAX_WINDOW);
		end
		raddr = old_idx[AW-1:0];
	end

	wrm_ring #(.DEPTH(MAX_WINDOW), .WIDTH(SAMPLE_W)) u_ring (
		.clk   (clk),
		.we    (accept),
		.waddr (head_q),
		.wdata (samples.sample_magnitude),
		.raddr (raddr),
		.rdata (old_mag)
	);

	assign s256 = {sum_q, {FRAC_W{1'b0}}};

	wrm_div #(.N_W(MW), .D_W(CW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_VAR),
		.dividend (s256),
		.divisor  (held_q),
		.busy     (div_busy),
		.quotient (quotient)
	);

	assign lhs       = RHS_W'({var_q, {VAR_SHIFT{1'b0}}});
	assign mean_diff = (tn_q > s256) ? tn_q - s256 : s256 - tn_q;
	assign tgt_diff  = (tgt_mag_q > mag_q) ? tgt_mag_q - mag_q : mag_q - tgt_mag_q;
	assign pol_ok    = (sgn_q == tgt_sign_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			held_q      <= '0;
			sum_q       <= '0;
			sq_q        <= '0;
			last_sign_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!out_valid_q || results.ready)) begin
				out_valid_q <= 1'b1;
			end else if (results.valid && results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (clear_c) begin
							held_q <= '0;
							sum_q  <= '0;
							sq_q   <= '0;
						end
						head_q      <= (head_q == AW'(MAX_WINDOW - 1)) ? '0 : head_q + 1'b1;
						last_sign_q <= samples.sample_sign;
						state_q     <= ST_OLD;
					end
				end
				ST_OLD: begin
					sum_q   <= sum_q - (drop_q ? SUM_W'(old_mag) : '0) + SUM_W'(mag_q);
					held_q  <= held_q - CW'(drop_q) + CW'(1);
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					sq_q    <= sq_q - (drop_q ? SQ_W'(old_sq_q) : '0) + SQ_W'(mag_sq_q);
					state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_VAR;
				ST_VAR: state_q <= ST_CMP;
				ST_CMP: state_q <= ST_DIV;
				ST_DIV: begin
					if (!div_busy) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || results.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q     <= samples.sample_magnitude;
			sgn_q     <= samples.sample_sign;
			cleared_q <= clear_c;
			drop_q    <= drop_c;
			mag_sq_q  <= samples.sample_magnitude * samples.sample_magnitude;
		end
		if (state_q == ST_OLD) begin
			old_sq_q <= old_mag * old_mag;
		end
		if (state_q == ST_MUL) begin
			p_nsq_q  <= PROD_W'(sq_q) * PROD_W'(held_q);
			p_sum2_q <= sum_q * sum_q;
			tol_n_q  <= spread_tol_q * held_q;
			tn_q     <= {SUM_W'(tgt_mag_q) * SUM_W'(held_q), {FRAC_W{1'b0}}};
			mt_q     <= MW'(mean_tol_q) * MW'(held_q);
		end
		if (state_q == ST_VAR) begin
			var_q <= p_nsq_q - p_sum2_q;
			rhs_q <= tol_n_q * tol_n_q;
		end
		if (state_q == ST_CMP) begin
			steady_q <= (held_q >= CW'(2)) && (lhs < rhs_q);
			on_tgt_q <= (held_q >= CW'(2)) && (lhs < rhs_q) && (mean_diff < mt_q)
				&& (hot_swap_q || pol_ok);
		end
		if (state_q == ST_OUT && (!out_valid_q || results.ready)) begin
			results.steady           <= steady_q;
			results.near_target      <= LIM_W'(tgt_diff) < near_tgt_lim_q;
			results.near_zero        <= LIM_W'(mag_q) < near_zero_lim_q;
			results.on_target        <= on_tgt_q;
			results.polarity_correct <= pol_ok;
			results.window_cleared   <= cleared_q;
			results.sample_count     <= COUNT_W'(EW'(held_q));
			results.mean_q8          <= quotient[MEAN_W-1:0];
		end
	end

	assign results.valid = out_valid_q;
endmodule

// ===== rtl/core/wrm_checker.sv =====
module wrm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       steady,
	input logic       on_target,
	input logic       cleared,
	input logic [5:0] count,
	input logic [23:0] mean
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(mean) && $stable(count))
		else $error("stalled result changed");

	a_on_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && on_target |-> steady)
		else $error("on target without steady signal");

	a_clear_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cleared |-> count == 6'd1)
		else $error("cleared window holds more than one sample");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second sample taken while one is in flight");
endmodule

bind windowed_regulation_monitor_top wrm_checker u_wrm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.steady    (results.steady),
	.on_target (results.on_target),
	.cleared   (results.window_cleared),
	.count     (results.sample_count),
	.mean      (results.mean_q8)
);

// ===== dv/windowed_regulation_monitor_top_tb.sv =====
`timescale 1ns / 1ps

module windowed_regulation_monitor_top_tb;
	import wrm_pkg::*;

	typedef struct packed {
		logic                steady;
		logic                near_t;
		logic                near_z;
		logic                on_t;
		logic                pol_ok;
		logic                cleared;
		logic [COUNT_W-1:0]  count;
		logic [MEAN_W-1:0]   mean;
	} status_t;

	// Predicts the monitor's status beats and holds them until they come out.
	class status_board;
		logic [SAMPLE_W-1:0] ring [DEF_MAX_WINDOW];
		int unsigned head, held;
		longint unsigned sum, sqsum;
		bit last_sgn;
		int unsigned win_len;
		bit hot_swap, tgt_sgn;
		int unsigned tgt_mag, near_t_lim, near_z_lim, mean_tol, spread_tol;
		status_t pending[$];
		int errors;

		function void clear_state();
			head = 0; held = 0; sum = 0; sqsum = 0; last_sgn = 0;
			win_len = 10; hot_swap = 0; tgt_mag = 0; tgt_sgn = 1;
			near_t_lim = 16; near_z_lim = 16; mean_tol = 256; spread_tol = 256;
			pending.delete(); errors = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
			case (idx)
				REG_WINDOW_LENGTH:     win_len = v[LEN_W-1:0];
				REG_HOT_POLARITY_SWAP: hot_swap = v[0];
				REG_TARGET_MAGNITUDE:  tgt_mag = v[LIM_W-1:0];
				REG_TARGET_SIGN:       tgt_sgn = v[0];
				REG_NEAR_TARGET_LIMIT: near_t_lim = v[LIM_W-1:0];
				REG_NEAR_ZERO_LIMIT:   near_z_lim = v[LIM_W-1:0];
				REG_MEAN_TOLERANCE:    mean_tol = v[TOL_W-1:0];
				REG_SPREAD_TOLERANCE:  spread_tol = v[TOL_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_sample(logic [SAMPLE_W-1:0] mag, bit sgn);
			status_t s;
			int unsigned len, oldest;
			longint unsigned n, lhs, rhs, tn, s256, d, m;
			len = (win_len == 0) ? 1 : (win_len > DEF_MAX_WINDOW ? DEF_MAX_WINDOW : win_len);
			m = mag;
			s = '0;
			if (held > 0 && sgn != last_sgn && !hot_swap) begin
				held = 0; sum = 0; sqsum = 0; s.cleared = 1;
			end
			if (held + 1 > len && held > 0) begin
				oldest = (head + DEF_MAX_WINDOW - held) % DEF_MAX_WINDOW;
				sum -= ring[oldest];
				sqsum -= longint'(ring[oldest]) * ring[oldest];
				held--;
			end
			ring[head] = mag;
			head = (head + 1) % DEF_MAX_WINDOW;
			held++;
			sum += m;
			sqsum += m * m;
			last_sgn = sgn;
			n = held;
			if (n >= 2) begin
				lhs = (n * sqsum - sum * sum) << VAR_SHIFT;
				rhs = longint'(spread_tol) * n;
				rhs = rhs * rhs;
				s.steady = lhs < rhs;
			end
			d = (tgt_mag > m) ? tgt_mag - m : m - tgt_mag;
			s.near_t = d < near_t_lim;
			s.near_z = m < near_z_lim;
			s.pol_ok = sgn == tgt_sgn;
			tn = (longint'(tgt_mag) * n) << FRAC_W;
			s256 = sum << FRAC_W;
			d = (tn > s256) ? tn - s256 : s256 - tn;
			s.on_t = (d < longint'(mean_tol) * n) && (hot_swap || s.pol_ok) && s.steady;
			s.count = n;
			s.mean = s256 / n;
			pending = {pending, s};
		endfunction

		function void check_status(status_t got);
			status_t exp;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result beat %p", got);
				return;
			end
			exp = pending.pop_front();
			if (got !== exp) begin
				errors++;
				if (errors <= 10) $display("mismatch: expected %p, got %p", exp, got);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	wrm_in_if samples();
	wrm_out_if results();
	wrm_cfg_if cfg();
	status_board board;
	longint unsigned cycles = 0;
	bit hold_ready = 0;
	int stall_phase = 0;

	windowed_regulation_monitor_top dut (
		.clk(clk), .arst_n(arst_n), .samples(samples), .results(results), .cfg(cfg)
	);

	always #2 clk = ~clk;

	initial begin
		samples.valid = 0; samples.sample_magnitude = 0; samples.sample_sign = 0;
		results.ready = 0;
		cfg.valid = 0; cfg.index = 0; cfg.data = 0;
	end

	// Receiver stalls follow a repeating pattern, with long stretches of no stall.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		stall_phase <= (stall_phase + 1) % 97;
		if (hold_ready || stall_phase < 40)
			results.ready <= 1;
		else
			results.ready <= ((stall_phase * 7) % 5) < 2;
		if (arst_n && results.valid && results.ready)
			board.check_status({results.steady, results.near_target, results.near_zero,
				results.on_target, results.polarity_correct, results.window_cleared,
				results.sample_count, results.mean_q8});
		if (cycles > 2000000) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic send_sample(logic [SAMPLE_W-1:0] mag, bit sgn);
		samples.valid <= 1;
		samples.sample_magnitude <= mag;
		samples.sample_sign <= sgn;
		@(posedge clk);
		while (!samples.ready) @(posedge clk);
		board.note_sample(mag, sgn);
		samples.valid <= 0;
		@(posedge clk);
	endtask

	task automatic idle_cycles(int k);
		repeat (k) @(posedge clk);
	endtask

	task automatic drain();
		while (board.pending.size() != 0) @(posedge clk);
		idle_cycles(50);
	endtask

	task automatic set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
		cfg.valid <= 1;
		cfg.index <= idx;
		cfg.data <= v;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		board.write_reg(idx, v);
		cfg.valid <= 0;
		@(posedge clk);
	endtask

	task automatic random_setting(bit extreme);
		set_reg(REG_WINDOW_LENGTH, extreme ? ($urandom_range(0, 1) ? 0 : 63) : $urandom_range(1, 40));
		set_reg(REG_HOT_POLARITY_SWAP, $urandom_range(0, 1));
		set_reg(REG_TARGET_MAGNITUDE, extreme ? 16'hffff : $urandom_range(0, 65535));
		set_reg(REG_TARGET_SIGN, $urandom_range(0, 1));
		set_reg(REG_NEAR_TARGET_LIMIT, extreme ? 16'hffff : $urandom_range(0, 65535));
		set_reg(REG_NEAR_ZERO_LIMIT, extreme ? 0 : $urandom_range(0, 65535));
		set_reg(REG_MEAN_TOLERANCE, extreme ? 24'hffffff : $urandom_range(0, 24'hffffff));
		set_reg(REG_SPREAD_TOLERANCE, $urandom_range(0, 1) ? 24'hffffff : $urandom_range(0, 40000));
	endtask

	// Samples cluster near a base value with a mostly stable sign so windows fill.
	task automatic random_phase(int count);
		int unsigned base;
		int unsigned spread;
		bit sgn;
		int burst;
		logic [SAMPLE_W-1:0] mag;
		base = $urandom_range(0, 65535);
		spread = 1 << $urandom_range(0, 16);
		sgn = $urandom_range(0, 1);
		burst = 0;
		for (int i = 0; i < count; i++) begin
			if (burst == 0) begin
				idle_cycles($urandom_range(0, 40));
				burst = $urandom_range(1, 12);
			end
			burst--;
			if ($urandom_range(0, 19) == 0) sgn = ~sgn;
			if ($urandom_range(0, 9) == 0)
				mag = $urandom_range(0, 65535);
			else
				mag = (base + $urandom_range(0, spread - 1)) & 16'hffff;
			send_sample(mag, sgn);
		end
	endtask

	initial begin
		board = new();
		board.clear_state();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: defaults, first sample with negative sign, extremes, polarity change.
		send_sample(16'h0000, 0);
		send_sample(16'h0000, 0);
		send_sample(16'hffff, 0);
		send_sample(16'h000f, 1);
		send_sample(16'h0010, 1);
		send_sample(16'h0010, 1);
		drain();
		set_reg(REG_WINDOW_LENGTH, 2);
		set_reg(REG_TARGET_MAGNITUDE, 16'h1000);
		for (int i = 0; i < 6; i++) send_sample(16'h1000, 1);
		send_sample(16'hffff, 1);
		drain();
		// Raised window length grows one sample at a time.
		set_reg(REG_WINDOW_LENGTH, 32);
		for (int i = 0; i < 3; i++) send_sample(16'hffff, 1);
		drain();
		set_reg(REG_WINDOW_LENGTH, 0);
		set_reg(REG_HOT_POLARITY_SWAP, 1);
		send_sample(16'h1234, 0);
		send_sample(16'h1234, 1);
		drain();
		set_reg(REG_WINDOW_LENGTH, 63);
		send_sample(16'h8000, 0);
		send_sample(16'h7fff, 1);
		drain();

		for (int p = 0; p < 25; p++) begin
			hold_ready = (p % 6 == 5);
			random_setting(p % 4 == 0);
			random_phase(50);
			drain();
		end

		if (board.errors == 0 && board.pending.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
